[hdl/calendar_date_info_unit_assert.svh]
// assertion macros for the calendar date info unit
// each check is sampled on clk and is off while arst_n is low
`ifndef CALENDAR_DATE_INFO_UNIT_ASSERT_SVH
`define CALENDAR_DATE_INFO_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define CDI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calendar date info check failed");

// antecedent implies consequent in the next cycle
`define CDI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calendar date info check failed");

`else

`define CDI_ASSERT_SAME(lbl, ante, cons)
`define CDI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/cdi_pkg.sv]
`timescale 1ns / 1ps

package cdi_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int YY_W    = 15;
	localparam int DOY_W   = 9;
	localparam int WD_W    = 3;
	localparam int PROD_W  = 28;
	localparam int QUOT_W  = 8;

	localparam int MONTH_JAN = 1;
	localparam int MONTH_FEB = 2;
	localparam int MONTH_DEC = 12;

	// year offset of the julian day number epoch
	localparam int JDN_YEAR_BASE = 4800;
	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**15
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int HUNDRED     = 100;
	// 7*31 to keep the subtracted century count positive, plus -32045 mod 7
	localparam int WD_BIAS     = 218;
	localparam int WEEK_LEN    = 7;

	typedef struct packed {
		logic                ok;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
		logic [YY_W-1:0]     yy;
		logic [MONTH_W-1:0]  mm;
		logic [PROD_W-1:0]   prod_y;
		logic [PROD_W-1:0]   prod_yy;
	} front_t;

	typedef struct packed {
		logic                ok;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic                leap;
		logic [YY_W-1:0]     wsum;
	} mid_t;

	typedef struct packed {
		logic                valid_res;
		logic                leap_year;
		logic [DAY_W-1:0]    month_length;
		logic [DOY_W-1:0]    day_of_year;
		logic [WD_W-1:0]     weekday;
		logic [DAY_W-1:0]    previous_day;
		logic [DAY_W-1:0]    next_day;
	} info_t;

	// days in month m, zero for codes outside 1..12
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			default: len = '0;
		endcase
		return len;
	endfunction

	// days in the months before m
	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DOY_W-1:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((m > 4'(MONTH_FEB)) ? 9'(leap) : 9'd0);
	endfunction

	// (153*mm + 2) / 5 for the march-based month index
	function automatic logic [DOY_W-1:0] jdn_month_offset(input logic [MONTH_W-1:0] mm);
		logic [DOY_W-1:0] off;
		case (mm)
			4'd0:    off = 9'd0;
			4'd1:    off = 9'd31;
			4'd2:    off = 9'd61;
			4'd3:    off = 9'd92;
			4'd4:    off = 9'd122;
			4'd5:    off = 9'd153;
			4'd6:    off = 9'd184;
			4'd7:    off = 9'd214;
			4'd8:    off = 9'd245;
			4'd9:    off = 9'd275;
			4'd10:   off = 9'd306;
			4'd11:   off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

[hdl/calendar_date_info_unit.sv]
`timescale 1ns / 1ps
`include "calendar_date_info_unit_assert.svh"

// Gregorian date information unit. Each word on the date channel carries a
// day, a month and a proleptic year; each word on the info channel gives the
// validity flag, leap-year flag, month length, day of year, weekday (julian
// day number mod 7, 0 is Monday) and the day numbers of the neighbor dates.
// A date is invalid when the day is 0 or the month is outside 1..12, and all
// other fields of its result are then 0; the day is not checked against the
// month length. The unit is a three-stage pipeline that takes one date per
// cycle unless every stage is full and held; the first stage holds the two
// constant multiplies by the reciprocal of 100, the second the leap test and
// weekday sum, the third the mod 7 fold and the month tables. Each stage
// holds its word when the stage after it is full and held, so empty stages
// keep filling while a result waits on info_ready.
module calendar_date_info_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        date_valid,
	output logic                        date_ready,
	input  logic [cdi_pkg::DAY_W-1:0]   day,
	input  logic [cdi_pkg::MONTH_W-1:0] month,
	input  logic [cdi_pkg::YEAR_W-1:0]  year,
	output logic                        info_valid,
	input  logic                        info_ready,
	output logic                        valid_res,
	output logic                        leap_year,
	output logic [cdi_pkg::DAY_W-1:0]   month_length,
	output logic [cdi_pkg::DOY_W-1:0]   day_of_year,
	output logic [cdi_pkg::WD_W-1:0]    weekday,
	output logic [cdi_pkg::DAY_W-1:0]   previous_day,
	output logic [cdi_pkg::DAY_W-1:0]   next_day
);
	import cdi_pkg::*;

	logic   front_valid;
	logic   front_ready;
	front_t front_data;
	logic   mid_valid;
	logic   mid_ready;
	mid_t   mid_data;
	info_t  info;

	// stage one: range check and reciprocal products
	cdi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (date_valid),
		.in_ready  (date_ready),
		.day       (day),
		.month     (month),
		.year      (year),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	// stage two: leap year and weekday sum
	cdi_mid u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	// stage three: weekday, lengths, ordinal day, output register
	cdi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (info_valid),
		.out_ready (info_ready),
		.out_data  (info)
	);

	assign valid_res    = info.valid_res;
	assign leap_year    = info.leap_year;
	assign month_length = info.month_length;
	assign day_of_year  = info.day_of_year;
	assign weekday      = info.weekday;
	assign previous_day = info.previous_day;
	assign next_day     = info.next_day;

	// input stalls only when every stage is full and the output is held
	`CDI_ASSERT_SAME(a_stall_full, !date_ready, info_valid && !info_ready)
	// invalid dates give an all-zero result
	`CDI_ASSERT_SAME(a_invalid_zero, info_valid && !valid_res, leap_year == 1'b0 && month_length == '0 && day_of_year == '0 && weekday == '0 && previous_day == '0 && next_day == '0)
	// valid results stay inside their ranges
	`CDI_ASSERT_SAME(a_valid_range, info_valid && valid_res, weekday < 3'd7 && month_length >= 5'd28 && day_of_year != '0 && next_day != '0 && previous_day != '0)
	// a held result stays valid until taken
	`CDI_ASSERT_NEXT(a_hold_valid, info_valid && !info_ready, info_valid)

endmodule

[hdl/cdi_front.sv]
`timescale 1ns / 1ps

module cdi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cdi_pkg::DAY_W-1:0]   day,
	input  logic [cdi_pkg::MONTH_W-1:0] month,
	input  logic [cdi_pkg::YEAR_W-1:0]  year,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cdi_pkg::front_t             out_data
);
	import cdi_pkg::*;

	logic   valid_s1;
	front_t data_s1;
	front_t nxt;
	logic   early;

	// range check, march-based year and month, reciprocal products for /100
	always_comb begin
		early       = (month <= MONTH_W'(MONTH_FEB));
		nxt.ok      = (day != '0) && (month inside {[MONTH_JAN:MONTH_DEC]});
		nxt.day     = day;
		nxt.month   = month;
		nxt.year    = year;
		nxt.yy      = YY_W'(year) + YY_W'(JDN_YEAR_BASE) - YY_W'(early);
		nxt.mm      = early ? (month + 4'd9) : (month - 4'd3);
		nxt.prod_y  = PROD_W'(year) * PROD_W'(RECIP_100);
		nxt.prod_yy = PROD_W'(nxt.yy) * PROD_W'(RECIP_100);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[hdl/cdi_mid.sv]
`timescale 1ns / 1ps

module cdi_mid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cdi_pkg::front_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output cdi_pkg::mid_t   out_data
);
	import cdi_pkg::*;

	logic              valid_s2;
	mid_t              data_s2;
	mid_t              nxt;
	logic [QUOT_W-1:0] qy;
	logic [QUOT_W-1:0] qyy;
	logic [YEAR_W-1:0] rem100;

	// quotients by 100, leap test, weekday sum reduced with 365 = 1 mod 7
	always_comb begin
		qy     = in_data.prod_y[RECIP_SHIFT +: QUOT_W];
		qyy    = in_data.prod_yy[RECIP_SHIFT +: QUOT_W];
		rem100 = in_data.year - YEAR_W'(YEAR_W'(qy) * YEAR_W'(HUNDRED));
		nxt.ok    = in_data.ok;
		nxt.day   = in_data.day;
		nxt.month = in_data.month;
		nxt.leap  = ((in_data.year[1:0] == 2'b00) && (rem100 != '0))
			|| ((rem100 == '0) && (qy[1:0] == 2'b00));
		nxt.wsum  = YY_W'(in_data.day) + YY_W'(jdn_month_offset(in_data.mm))
			+ in_data.yy + YY_W'(in_data.yy >> 2) + YY_W'(qyy >> 2)
			+ YY_W'(WD_BIAS) - YY_W'(qyy);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

[hdl/cdi_back.sv]
`timescale 1ns / 1ps

module cdi_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cdi_pkg::mid_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output cdi_pkg::info_t  out_data
);
	import cdi_pkg::*;

	logic             valid_s3;
	info_t            data_s3;
	info_t            nxt;
	logic [5:0]       fold1;
	logic [3:0]       fold2;
	logic [DAY_W-1:0] mlen;

	// mod 7 by folding octal digits, then tables for lengths and ordinal
	always_comb begin
		fold1 = 6'(in_data.wsum[2:0]) + 6'(in_data.wsum[5:3]) + 6'(in_data.wsum[8:6])
			+ 6'(in_data.wsum[11:9]) + 6'(in_data.wsum[14:12]);
		fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
		mlen  = month_len(in_data.month, in_data.leap);
		nxt   = '0;
		if (in_data.ok) begin
			nxt.valid_res    = 1'b1;
			nxt.leap_year    = in_data.leap;
			nxt.month_length = mlen;
			nxt.day_of_year  = DOY_W'(in_data.day) + days_before(in_data.month, in_data.leap);
			nxt.weekday      = (fold2 >= 4'(WEEK_LEN)) ? WD_W'(fold2 - 4'(WEEK_LEN))
				: WD_W'(fold2);
			if (in_data.day == 5'd1) begin
				nxt.previous_day = (in_data.month == MONTH_W'(MONTH_JAN)) ? 5'd31
					: month_len(in_data.month - 4'd1, in_data.leap);
			end else begin
				nxt.previous_day = in_data.day - 5'd1;
			end
			nxt.next_day = (in_data.day >= mlen) ? 5'd1 : (in_data.day + 5'd1);
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

[dv/calendar_date_info_unit_test.sv]
`timescale 1ns / 1ps

module calendar_date_info_unit_test;
	import cdi_pkg::*;

	localparam int CLK_HALF_NS      = 2;
	localparam int RESET_CYCLES     = 2;
	localparam int MAX_REPORTS      = 10;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT      = 2000;
	localparam int TAIL_CYCLES      = 8;
	localparam int RUN_LIMIT_NS     = 2_000_000;
	localparam int RANDOM_PER_PHASE = 110;
	localparam int PRESSURE_DATES   = 40;
	localparam int JDN_OFFSET       = 32045;
	localparam int YEAR_MAX         = 2**YEAR_W - 1;
	localparam int YEAR_NOMINAL_MAX = 9999;

	typedef struct packed {
		logic             valid_res;
		logic             leap_year;
		logic [DAY_W-1:0] month_length;
		logic [DOY_W-1:0] day_of_year;
		logic [WD_W-1:0]  weekday;
		logic [DAY_W-1:0] previous_day;
		logic [DAY_W-1:0] next_day;
	} date_info_t;

	typedef struct {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		date_info_t         info;
	} pending_date_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 date_valid = 1'b0;
	logic                 date_ready;
	logic [DAY_W-1:0]     day = '0;
	logic [MONTH_W-1:0]   month = '0;
	logic [YEAR_W-1:0]    year = '0;
	logic                 info_valid;
	logic                 info_ready = 1'b0;
	logic                 valid_res;
	logic                 leap_year;
	logic [DAY_W-1:0]     month_length;
	logic [DOY_W-1:0]     day_of_year;
	logic [WD_W-1:0]      weekday;
	logic [DAY_W-1:0]     previous_day;
	logic [DAY_W-1:0]     next_day;

	pending_date_t        expected_info[$];
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_req = 0;
	int                   hold_ack = 0;
	int                   hold_left = 0;
	int                   fail_count = 0;
	int                   dates_sent = 0;
	int                   invalid_dates = 0;
	int                   leap_dates = 0;
	int                   words_checked = 0;
	int                   input_wait_cycles = 0;

	calendar_date_info_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.date_valid   (date_valid),
		.date_ready   (date_ready),
		.day          (day),
		.month        (month),
		.year         (year),
		.info_valid   (info_valid),
		.info_ready   (info_ready),
		.valid_res    (valid_res),
		.leap_year    (leap_year),
		.month_length (month_length),
		.day_of_year  (day_of_year),
		.weekday      (weekday),
		.previous_day (previous_day),
		.next_day     (next_day)
	);

	always #CLK_HALF_NS clk = ~clk;

	// gregorian leap rule
	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// length of a valid month
	function automatic int unsigned days_of(input int unsigned m, input bit leap);
		case (m)
			MONTH_FEB: return 28 + leap;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// expected info word for one date
	function automatic date_info_t predict_date_info(input logic [DAY_W-1:0] d_in,
			input logic [MONTH_W-1:0] m_in, input logic [YEAR_W-1:0] y_in);
		date_info_t  info;
		int unsigned d, m, y, mlen, doy, march_shift, ey, em, jdn, prev;
		bit          leap;
		info = '0;
		d = 32'(d_in);
		m = 32'(m_in);
		y = 32'(y_in);
		if (d == 0 || m < MONTH_JAN || m > MONTH_DEC)
			return info;
		leap = is_leap_year(y);
		mlen = days_of(m, leap);
		doy = d;
		for (int unsigned k = MONTH_JAN; k < m; k++)
			doy += days_of(k, leap);
		// julian day number with the year starting in march
		march_shift = (14 - m) / 12;
		ey = y + JDN_YEAR_BASE - march_shift;
		em = m + 12 * march_shift - 3;
		jdn = d + (153 * em + 2) / 5 + 365 * ey + ey / 4 - ey / 100 + ey / 400 - JDN_OFFSET;
		if (d != 1)
			prev = d - 1;
		else if (m == MONTH_JAN)
			prev = days_of(MONTH_DEC, leap);
		else
			prev = days_of(m - 1, leap);
		info.valid_res    = 1'b1;
		info.leap_year    = leap;
		info.month_length = DAY_W'(mlen);
		info.day_of_year  = DOY_W'(doy);
		info.weekday      = WD_W'(jdn % WEEK_LEN);
		info.previous_day = DAY_W'(prev);
		info.next_day     = (d >= mlen) ? DAY_W'(1) : DAY_W'(d + 1);
		return info;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input pending_date_t exp_word,
			input int want, input int got);
		if (want != got)
			note_failure($sformatf("%0d/%0d/%0d %s: expected %0d, got %0d",
				exp_word.day, exp_word.month, exp_word.year, name, want, got));
	endtask

	// reset, released on a clock edge
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_ack) begin
				hold_ack   <= hold_req;
				hold_left  <= LONG_HOLD_CYCLES;
				info_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left  <= hold_left - 1;
				info_ready <= 1'b0;
			end else
				info_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// scoreboard: check the info word first, then record the accepted date
	always @(posedge clk) begin : scoreboard
		pending_date_t exp_word;
		pending_date_t new_word;
		if (arst_n) begin
			if (info_valid && info_ready) begin
				if (expected_info.size() == 0)
					note_failure("info word with no date outstanding");
				else begin
					exp_word = expected_info.pop_front();
					words_checked++;
					check_field("valid_res", exp_word, int'(exp_word.info.valid_res),
						int'(valid_res));
					check_field("leap_year", exp_word, int'(exp_word.info.leap_year),
						int'(leap_year));
					check_field("month_length", exp_word, int'(exp_word.info.month_length),
						int'(month_length));
					check_field("day_of_year", exp_word, int'(exp_word.info.day_of_year),
						int'(day_of_year));
					check_field("weekday", exp_word, int'(exp_word.info.weekday),
						int'(weekday));
					check_field("previous_day", exp_word, int'(exp_word.info.previous_day),
						int'(previous_day));
					check_field("next_day", exp_word, int'(exp_word.info.next_day),
						int'(next_day));
				end
			end
			if (date_valid && !date_ready)
				input_wait_cycles++;
			if (date_valid && date_ready) begin
				new_word.day   = day;
				new_word.month = month;
				new_word.year  = year;
				new_word.info  = predict_date_info(day, month, year);
				expected_info.push_back(new_word);
				dates_sent++;
				if (!new_word.info.valid_res)
					invalid_dates++;
				if (new_word.info.leap_year)
					leap_dates++;
			end
		end
	end

	// offer one date word and return at the edge that accepts it
	task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			date_valid <= 1'b0;
			@(posedge clk);
		end
		date_valid <= 1'b1;
		day        <= d;
		month      <= m;
		year       <= y;
		@(posedge clk);
		while (!date_ready)
			@(posedge clk);
	endtask

	// drop valid and let every outstanding info word come back
	task automatic finish_stream();
		date_valid <= 1'b0;
		for (int c = 0; c < DRAIN_LIMIT && expected_info.size() != 0; c++)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// field extremes and year range ends
	task automatic test_field_extremes();
		set_idling(0, 0);
		send_date(5'd1, 4'd1, 14'd0);
		send_date(5'd31, 4'd12, 14'(YEAR_MAX));
		send_date(5'd31, 4'd12, 14'(YEAR_NOMINAL_MAX));
		send_date(5'd1, 4'd1, 14'd10000);
		send_date(5'd15, 4'd6, 14'h2AAA);
		send_date(5'd16, 4'd9, 14'h1555);
		finish_stream();
	endtask

	// day 0 and month codes outside 1..12
	task automatic test_invalid_dates();
		set_idling(0, 0);
		send_date(5'd0, 4'd5, 14'd2024);
		send_date(5'd10, 4'd0, 14'd2024);
		send_date(5'd10, 4'd13, 14'd1999);
		send_date(5'd31, 4'd15, 14'(YEAR_MAX));
		send_date(5'd0, 4'd0, 14'd0);
		finish_stream();
	endtask

	// leap rules, month turnovers and days past the month's end
	task automatic test_month_edges();
		set_idling(0, 0);
		send_date(5'd29, 4'd2, 14'd2000);
		send_date(5'd28, 4'd2, 14'd1900);
		send_date(5'd29, 4'd2, 14'd1900);
		send_date(5'd31, 4'd2, 14'd2023);
		send_date(5'd1, 4'd3, 14'd2024);
		send_date(5'd1, 4'd3, 14'd2023);
		send_date(5'd1, 4'd1, 14'd2024);
		send_date(5'd31, 4'd12, 14'd2024);
		send_date(5'd1, 4'd5, 14'd2021);
		send_date(5'd31, 4'd4, 14'd2021);
		send_date(5'd30, 4'd4, 14'd2021);
		finish_stream();
	endtask

	// mostly well-formed dates, the rest raw field noise
	task automatic test_random_dates(input int count, input int idle_pct,
			input int stall_pct);
		logic [DAY_W-1:0]   d;
		logic [MONTH_W-1:0] m;
		logic [YEAR_W-1:0]  y;
		set_idling(idle_pct, stall_pct);
		repeat (count) begin
			if ($urandom_range(99) < 75) begin
				y = ($urandom_range(9) == 0)
					? YEAR_W'($urandom_range(YEAR_MAX, YEAR_NOMINAL_MAX + 1))
					: YEAR_W'($urandom_range(YEAR_NOMINAL_MAX));
				m = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
				d = DAY_W'($urandom_range(days_of(32'(m), is_leap_year(32'(y))), 1));
			end else begin
				d = DAY_W'($urandom);
				m = MONTH_W'($urandom);
				y = YEAR_W'($urandom);
			end
			send_date(d, m, y);
		end
		finish_stream();
	endtask

	// long receiver hold-off while dates keep coming, so the pipe backs up
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_req <= hold_req + 1;
		@(posedge clk);
		repeat (PRESSURE_DATES)
			send_date(DAY_W'($urandom_range(28, 1)),
				MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN)),
				YEAR_W'($urandom_range(YEAR_NOMINAL_MAX)));
		finish_stream();
	endtask

	// test sequence
	initial begin
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		test_field_extremes();
		test_invalid_dates();
		test_month_edges();
		test_random_dates(RANDOM_PER_PHASE, 0, 0);
		test_random_dates(RANDOM_PER_PHASE, 75, 0);
		test_random_dates(RANDOM_PER_PHASE, 0, 75);
		test_random_dates(RANDOM_PER_PHASE, 37, 37);
		test_backpressure();
		foreach (expected_info[i])
			note_failure($sformatf("no info word for %0d/%0d/%0d", expected_info[i].day,
				expected_info[i].month, expected_info[i].year));
		$display("dates sent %0d (invalid %0d, leap year %0d), info words checked %0d",
			dates_sent, invalid_dates, leap_dates, words_checked);
		$display("input held back %0d cycles under receiver stalls, failures %0d",
			input_wait_cycles, fail_count);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#RUN_LIMIT_NS;
		$display("timeout with %0d info words outstanding", expected_info.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
